FILE: design/bmpm_pkg.sv
package bmpm_pkg;

  // source pixel depth codes (register value 3 is handled as 24-bit)
  typedef enum logic [1:0] {
    DEPTH_1BPP  = 2'd0,
    DEPTH_8BPP  = 2'd1,
    DEPTH_24BPP = 2'd2
  } depth_mode_t;

  // register indexes of the configuration port
  localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int DIM_W       = 13;
  localparam int ADDR_W      = 21;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [1:0]       RST_DEPTH_MODE   = 2'd0;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd152;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd296;

  // luma weights and black threshold
  localparam logic [7:0] LUMA_R       = 8'd77;
  localparam logic [7:0] LUMA_G       = 8'd150;
  localparam logic [7:0] LUMA_B       = 8'd29;
  localparam logic [7:0] BLACK_THRESH = 8'd128;

  localparam logic [7:0] PACK_MSB  = 8'h80;
  localparam logic [7:0] PACK_INIT = 8'hFF;

endpackage

FILE: design/bmpm_luma.sv
module bmpm_luma
  import bmpm_pkg::*;
(
  input  logic [7:0] comp_b,
  input  logic [7:0] comp_g,
  input  logic [7:0] comp_r,
  output logic       is_black
);

  logic [15:0] luma_sum;
  logic [7:0]  gray;

  // weights sum to 256, so the sum never exceeds 16 bits
  assign luma_sum = 16'(comp_r) * 16'(LUMA_R)
                  + 16'(comp_g) * 16'(LUMA_G)
                  + 16'(comp_b) * 16'(LUMA_B);
  assign gray     = luma_sum[15:8];
  assign is_black = gray < BLACK_THRESH;

endmodule

FILE: design/bitmap_pixels_to_mono_packer_core.sv
// bmp pixel array to 1-bpp packer
//
// input channel: in_valid / in_stall with raw_byte, one byte of the bmp pixel
// array per beat in file order, row padding included. output channel:
// out_valid / out_stall with packed_byte, byte_address and last_of_image.
// a beat moves when valid is high and stall is low at a rising edge.
// configuration: cfg_we writes cfg_data into register cfg_index (0 depth
// mode, 1 width, 2 height). any write, even to an unused index, restarts
// the image. write only while the block holds no beat.
// a byte accepted goes into the input register, is classified and packed on
// its way into the result register, which presents its packed byte (if any).
// one byte per cycle sustained while the receiver does not stall: classify
// and pack are combinational between the input register and the result
// register, and the row counters update every beat.
// when the receiver stalls, the result register holds and the input
// register stops behind it; in_stall rises once the input register is full
// and cannot drain. padding beats need no result slot but still wait.
// reset (rst, synchronous): registers go to depth 1-bit, width 152,
// height 296, and the stream restarts at row 0 with no beat pending.
module bitmap_pixels_to_mono_packer_core
  import bmpm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             raw_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             packed_byte,
  output logic [ADDR_W-1:0]      byte_address,
  output logic                   last_of_image
);

  // width of a pixel count that can hold MAX_WIDTH itself
  localparam int WW = $clog2(MAX_WIDTH + 1);
  // output bytes per row
  localparam int OB = $clog2((MAX_WIDTH + 7) / 8 + 1);
  // source bytes per row, worst case 24-bit
  localparam int RB = $clog2(3 * MAX_WIDTH + 4);
  localparam int SW = RB + 2;
  localparam int HV = $clog2(MAX_HEIGHT + 1);
  localparam int HB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [1:0]       pixel_depth_mode;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  // stream state
  logic [RB-1:0]     row_byte_position, row_byte_position_next;
  logic [WW-1:0]     pixel_column, pixel_column_next;
  logic [HB-1:0]     file_row, file_row_next;
  logic [15:0]       held_components, held_components_next;
  logic [1:0]        component_index, component_index_next;
  logic [7:0]        packing_byte, packing_byte_next;
  logic [ADDR_W-1:0] row_base, row_base_next;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;

  // derived geometry
  logic [WW-1:0] w_eff;
  logic [HV-1:0] h_eff;
  logic [OB-1:0] orb;
  logic [RB-1:0] srb;
  logic [SW-1:0] w_x;
  logic [SW-1:0] srb_x;

  // result of the current beat
  logic              res_hit;
  logic [7:0]        res_byte;
  logic [ADDR_W-1:0] res_addr;
  logic              res_last;

  logic          luma_black;
  logic          pix_black;
  logic          pix_have;
  logic [2:0]    pix_bit;
  logic [7:0]    pack_cleared;
  logic          row_last_pix;
  logic          last_row;
  logic          row_end;
  logic          rbp_last;
  logic [RB-1:0] rbp_inc;

  // clamp width and height into their usable range
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HV'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HV'(MAX_HEIGHT);
    end else begin
      h_eff = HV'(image_height);
    end
  end

  assign w_x = SW'(w_eff);
  assign orb = OB'((w_x + SW'(7)) >> 3);

  // source rows are padded to four bytes
  always_comb begin
    case (pixel_depth_mode)
      DEPTH_1BPP: srb_x = ((w_x + SW'(31)) >> 5) << 2;
      DEPTH_8BPP: srb_x = ((w_x + SW'(3)) >> 2) << 2;
      default:    srb_x = ((w_x * SW'(3) + SW'(3)) >> 2) << 2;
    endcase
  end
  assign srb = RB'(srb_x);

  bmpm_luma u_luma (
    .comp_b   (held_components[7:0]),
    .comp_g   (held_components[15:8]),
    .comp_r   (s1_byte),
    .is_black (luma_black)
  );

  // the input register drains whenever the result slot is free or leaving
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  assign rbp_inc      = RB'(row_byte_position + RB'(1));
  assign rbp_last     = row_byte_position == RB'(orb - OB'(1));
  assign row_last_pix = pixel_column == WW'(w_eff - WW'(1));
  assign last_row     = file_row == HB'(h_eff - HV'(1));
  assign row_end      = rbp_inc >= srb;
  assign pix_bit      = pixel_column[2:0];
  assign pack_cleared = pix_black ? (packing_byte & ~(PACK_MSB >> pix_bit)) : packing_byte;

  // a pixel completes on every gray byte or on the red byte of a bgr triple
  always_comb begin
    pix_black = 1'b0;
    pix_have  = 1'b0;
    if ((pixel_depth_mode != DEPTH_1BPP) && (pixel_column < w_eff)) begin
      if (pixel_depth_mode == DEPTH_8BPP) begin
        pix_black = s1_byte < BLACK_THRESH;
        pix_have  = 1'b1;
      end else if (component_index[1]) begin
        pix_black = luma_black;
        pix_have  = 1'b1;
      end
    end
  end

  always_comb begin
    row_byte_position_next = row_byte_position;
    pixel_column_next      = pixel_column;
    file_row_next          = file_row;
    held_components_next   = held_components;
    component_index_next   = component_index;
    packing_byte_next      = packing_byte;
    row_base_next          = row_base;
    res_hit                = 1'b0;
    res_byte               = pack_cleared;
    res_addr               = ADDR_W'(row_base + ADDR_W'(pixel_column >> 3));
    res_last               = last_row && row_last_pix;

    if (pixel_depth_mode == DEPTH_1BPP) begin
      // bytes already hold packed pixels, only the tail past the width is forced white
      res_addr = ADDR_W'(row_base + ADDR_W'(row_byte_position));
      res_last = last_row && rbp_last;
      res_byte = s1_byte;
      if (rbp_last && (w_eff[2:0] != 3'd0)) begin
        res_byte = s1_byte | (PACK_INIT >> w_eff[2:0]);
      end
      res_hit = row_byte_position < RB'(orb);
    end else if (pixel_column < w_eff) begin
      if (pixel_depth_mode != DEPTH_8BPP) begin
        case (component_index)
          2'd0: begin
            held_components_next = {held_components[15:8], s1_byte};
            component_index_next = 2'd1;
          end
          2'd1: begin
            held_components_next = {s1_byte, held_components[7:0]};
            component_index_next = 2'd2;
          end
          default: begin
            component_index_next = 2'd0;
          end
        endcase
      end
      if (pix_have) begin
        packing_byte_next = pack_cleared;
        if ((pix_bit == 3'd7) || row_last_pix) begin
          res_hit           = 1'b1;
          packing_byte_next = PACK_INIT;
        end
        pixel_column_next = WW'(pixel_column + WW'(1));
      end
    end

    row_byte_position_next = rbp_inc;
    if (row_end) begin
      row_byte_position_next = '0;
      pixel_column_next      = '0;
      component_index_next   = 2'd0;
      packing_byte_next      = PACK_INIT;
      if (last_row) begin
        file_row_next = '0;
        row_base_next = '0;
      end else begin
        file_row_next = HB'(file_row + HB'(1));
        row_base_next = ADDR_W'(row_base + ADDR_W'(orb));
      end
    end
  end

  // stream state, cleared on reset and on every configuration write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_byte_position <= '0;
      pixel_column      <= '0;
      file_row          <= '0;
      held_components   <= '0;
      component_index   <= 2'd0;
      packing_byte      <= PACK_INIT;
      row_base          <= '0;
    end else if (s1_adv) begin
      row_byte_position <= row_byte_position_next;
      pixel_column      <= pixel_column_next;
      file_row          <= file_row_next;
      held_components   <= held_components_next;
      component_index   <= component_index_next;
      packing_byte      <= packing_byte_next;
      row_base          <= row_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth_mode <= RST_DEPTH_MODE;
      image_width      <= RST_IMAGE_WIDTH;
      image_height     <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_MODE:   pixel_depth_mode <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width      <= cfg_data;
        REG_IMAGE_HEIGHT: image_height     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= raw_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= res_hit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_hit) begin
      packed_byte   <= res_byte;
      byte_address  <= res_addr;
      last_of_image <= res_last;
    end
  end

  // checks
  a_rbp_in_row: assert property (@(posedge clk) disable iff (rst)
    row_byte_position < srb)
    else $error("row byte position past source row length");

  a_col_in_width: assert property (@(posedge clk) disable iff (rst)
    pixel_column <= w_eff)
    else $error("pixel column past image width");

  a_row_in_height: assert property (@(posedge clk) disable iff (rst)
    HV'(file_row) < h_eff)
    else $error("file row past image height");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with nothing blocking");

endmodule
